// ===== src/kdve_pkg.sv =====
// shared types, constants and helpers for the keyed decimal value extractor
package kdve_pkg;

  localparam int VALUE_BITS = 32;
  localparam int POW_BITS   = 30;
  localparam int PROD_BITS  = VALUE_BITS + POW_BITS;
  localparam int CFG_BITS   = 32;
  localparam int FRAC_MAX   = 9;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_POINT = 8'h2e;

  localparam logic [7:0] KEY_RESET = 8'h58;

  typedef enum logic [1:0] {
    CFG_KEY_LETTER    = 2'd0,
    CFG_FRAC_DIGITS   = 2'd1,
    CFG_DEFAULT_VALUE = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_COLLECT = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_DEFAULT   = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_SATURATED = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    status_t                      status;
  } out_item_t;

  // parse state of the line being read
  typedef struct packed {
    phase_t                phase;
    logic                  is_negative;
    logic                  seen_point;
    logic [VALUE_BITS-1:0] magnitude;
    logic [3:0]            fraction_count;
    logic                  collected_any;
    logic                  malformed;
    logic                  saturated;
  } line_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] magnitude;
    logic [3:0]            pad;
    logic                  is_negative;
    logic                  collected_any;
    logic                  malformed;
    logic                  saturated;
  } fin_t;

  typedef struct packed {
    logic [PROD_BITS-1:0] product;
    logic                 is_negative;
    logic                 collected_any;
    logic                 malformed;
    logic                 saturated;
  } prd_t;

  function automatic logic [VALUE_BITS-1:0] limit_of(input logic neg);
    logic [VALUE_BITS-1:0] lim;
    lim = neg ? {1'b1, {(VALUE_BITS-1){1'b0}}} : {1'b0, {(VALUE_BITS-1){1'b1}}};
    return lim;
  endfunction

  function automatic logic [POW_BITS-1:0] pow10(input logic [3:0] k);
    logic [POW_BITS-1:0] p;
    unique case (k)
      4'd0:    p = POW_BITS'(1);
      4'd1:    p = POW_BITS'(10);
      4'd2:    p = POW_BITS'(100);
      4'd3:    p = POW_BITS'(1000);
      4'd4:    p = POW_BITS'(10000);
      4'd5:    p = POW_BITS'(100000);
      4'd6:    p = POW_BITS'(1000000);
      4'd7:    p = POW_BITS'(10000000);
      4'd8:    p = POW_BITS'(100000000);
      4'd9:    p = POW_BITS'(1000000000);
      default: p = POW_BITS'(1);
    endcase
    return p;
  endfunction

endpackage

// ===== src/kdve_parse.sv =====
// per-character parse state: key search, sign, point and saturating digit accumulate
module kdve_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  kdve_pkg::in_item_t   item,
  input  logic [7:0]           key_letter,
  input  logic [3:0]           frac_eff,
  output kdve_pkg::line_t      line_nxt
);

  kdve_pkg::line_t line_r;

  logic                              is_digit;
  logic [3:0]                        digit;
  logic                              take_digit;
  logic [kdve_pkg::VALUE_BITS-1:0]   lim;
  logic [kdve_pkg::VALUE_BITS+3:0]   acc;

  assign is_digit = (item.char_code >= kdve_pkg::CH_ZERO) &&
                    (item.char_code <= kdve_pkg::CH_NINE);
  assign digit    = item.char_code[3:0];
  assign lim      = kdve_pkg::limit_of(line_r.is_negative);
  assign acc      = ((kdve_pkg::VALUE_BITS+4)'(line_r.magnitude) << 3) +
                    ((kdve_pkg::VALUE_BITS+4)'(line_r.magnitude) << 1) +
                    (kdve_pkg::VALUE_BITS+4)'(digit);
  assign take_digit = !line_r.seen_point || (line_r.fraction_count < frac_eff);

  always_comb begin
    line_nxt = line_r;
    unique case (line_r.phase)
      kdve_pkg::PH_SEARCH: begin
        if (item.char_code == key_letter) begin
          line_nxt.phase = kdve_pkg::PH_COLLECT;
        end
      end
      kdve_pkg::PH_COLLECT: begin
        priority if (is_digit) begin
          if (take_digit) begin
            if (line_r.saturated || acc > (kdve_pkg::VALUE_BITS+4)'(lim)) begin
              line_nxt.magnitude = lim;
              line_nxt.saturated = 1'b1;
            end else begin
              line_nxt.magnitude = acc[kdve_pkg::VALUE_BITS-1:0];
            end
            if (line_r.seen_point) begin
              line_nxt.fraction_count = line_r.fraction_count + 4'd1;
            end
          end
          line_nxt.collected_any = 1'b1;
        end else if (item.char_code == kdve_pkg::CH_MINUS ||
                     item.char_code == kdve_pkg::CH_PLUS) begin
          if (line_r.collected_any) begin
            line_nxt.malformed = 1'b1;
          end else if (item.char_code == kdve_pkg::CH_MINUS) begin
            line_nxt.is_negative = 1'b1;
          end
          line_nxt.collected_any = 1'b1;
        end else if (item.char_code == kdve_pkg::CH_POINT) begin
          if (line_r.seen_point) begin
            line_nxt.malformed = 1'b1;
          end
          line_nxt.seen_point    = 1'b1;
          line_nxt.collected_any = 1'b1;
        end else begin
          line_nxt.phase = kdve_pkg::PH_DONE;
        end
      end
      default: begin
        line_nxt = line_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= '0;
    end else if (step) begin
      if (item.last_char) begin
        line_r <= '0;
      end else begin
        line_r <= line_nxt;
      end
    end
  end

endmodule

// ===== src/keyed_decimal_value_extractor.sv =====
// top level: input register, line parser, fraction padding and result stages
//
//   channel   direction   ports                          beat
//   in        input       in_valid  in_stall  in_data    one character, last_char ends line
//   out       output      out_valid out_stall out_data   one value and status per line
//   cfg       input       cfg_we cfg_addr cfg_wdata      register write, no handshake
//
// one character per cycle sustained while the pad stage has room for each last character;
// once its last character leaves the input register, a line's result moves through the pad
// stage, the 32x30 scale multiply that pads missing fraction digits and the output register.
// reset is synchronous and clears valids, parse state and config registers to defaults.
// a stalled output holds its stage and full stages right behind it; earlier stages keep filling bubbles.
module keyed_decimal_value_extractor (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  kdve_pkg::in_item_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output kdve_pkg::out_item_t   out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_addr,
  input  logic [kdve_pkg::CFG_BITS-1:0] cfg_wdata
);

  logic [7:0]                         key_r;
  logic [3:0]                         frac_r;
  logic [kdve_pkg::CFG_BITS-1:0]      default_r;
  logic [3:0]                         frac_eff;

  logic                               in_v_r;
  kdve_pkg::in_item_t                 in_r;
  logic                               fin_v_r;
  kdve_pkg::fin_t                     fin_r;
  logic                               prd_v_r;
  kdve_pkg::prd_t                     prd_r;
  logic                               out_valid_r;
  kdve_pkg::out_item_t                out_r;
  kdve_pkg::out_item_t                out_nxt;

  logic                               out_free;
  logic                               prd_free;
  logic                               fin_free;
  logic                               in_fire;
  logic                               in_accept;
  logic                               fin_load;
  kdve_pkg::line_t                    line_nxt;

  logic [kdve_pkg::VALUE_BITS-1:0]    lim;
  logic                               ovf;
  logic [kdve_pkg::VALUE_BITS-1:0]    mag;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= kdve_pkg::KEY_RESET;
      frac_r    <= '0;
      default_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        kdve_pkg::CFG_KEY_LETTER:    key_r     <= cfg_wdata[7:0];
        kdve_pkg::CFG_FRAC_DIGITS:   frac_r    <= cfg_wdata[3:0];
        kdve_pkg::CFG_DEFAULT_VALUE: default_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign frac_eff = (frac_r > 4'(kdve_pkg::FRAC_MAX)) ? 4'(kdve_pkg::FRAC_MAX) : frac_r;

  // stage handshakes: a full stage moves when the next has room; only a last character waits at the input
  assign out_free  = !out_valid_r || !out_stall;
  assign prd_free  = !prd_v_r || out_free;
  assign fin_free  = !fin_v_r || prd_free;
  assign in_fire   = in_v_r && (!in_r.last_char || fin_free);
  assign in_stall  = in_v_r && !in_fire;
  assign in_accept = in_valid && !in_stall;
  assign fin_load  = in_fire && in_r.last_char;

  kdve_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_fire),
    .item       (in_r),
    .key_letter (key_r),
    .frac_eff   (frac_eff),
    .line_nxt   (line_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      fin_v_r     <= 1'b0;
      prd_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        in_v_r <= 1'b1;
      end else if (in_fire) begin
        in_v_r <= 1'b0;
      end
      if (fin_free) begin
        fin_v_r <= fin_load;
      end
      if (prd_free) begin
        prd_v_r <= fin_v_r;
      end
      if (out_free) begin
        out_valid_r <= prd_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_r <= in_data;
    end
    if (fin_free && fin_load) begin
      fin_r.magnitude     <= line_nxt.magnitude;
      fin_r.pad           <= frac_eff - line_nxt.fraction_count;
      fin_r.is_negative   <= line_nxt.is_negative;
      fin_r.collected_any <= line_nxt.collected_any;
      fin_r.malformed     <= line_nxt.malformed;
      fin_r.saturated     <= line_nxt.saturated;
    end
    // scale by ten for each fraction digit that never arrived
    if (prd_free && fin_v_r) begin
      prd_r.product       <= kdve_pkg::PROD_BITS'(fin_r.magnitude) *
                             kdve_pkg::PROD_BITS'(kdve_pkg::pow10(fin_r.pad));
      prd_r.is_negative   <= fin_r.is_negative;
      prd_r.collected_any <= fin_r.collected_any;
      prd_r.malformed     <= fin_r.malformed;
      prd_r.saturated     <= fin_r.saturated;
    end
    if (out_free && prd_v_r) begin
      out_r <= out_nxt;
    end
  end

  assign lim = kdve_pkg::limit_of(prd_r.is_negative);
  assign ovf = prd_r.product > kdve_pkg::PROD_BITS'(lim);
  assign mag = ovf ? lim : prd_r.product[kdve_pkg::VALUE_BITS-1:0];

  always_comb begin
    priority if (!prd_r.collected_any) begin
      out_nxt.value  = kdve_pkg::VALUE_BITS'($signed(default_r));
      out_nxt.status = kdve_pkg::ST_DEFAULT;
    end else if (prd_r.malformed) begin
      out_nxt.value  = '0;
      out_nxt.status = kdve_pkg::ST_MALFORMED;
    end else begin
      out_nxt.value  = prd_r.is_negative ? -mag : mag;
      out_nxt.status = (prd_r.saturated || ovf) ? kdve_pkg::ST_SATURATED
                                                : kdve_pkg::ST_FOUND;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_malformed_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == kdve_pkg::ST_MALFORMED |-> out_r.value == '0)
    else $error("malformed result with nonzero value");

  a_saturated_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == kdve_pkg::ST_SATURATED |->
      out_r.value == kdve_pkg::limit_of(1'b0) || out_r.value == kdve_pkg::limit_of(1'b1))
    else $error("saturated result not at a range limit");

  a_prd_held: assert property (@(posedge clk) disable iff (!rst_n)
    prd_v_r && !out_free |=> prd_v_r && $stable(prd_r))
    else $error("multiply stage lost its beat while output stalled");

  a_in_moves_when_fin_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !fin_v_r |-> in_fire)
    else $error("input register stuck with pad stage empty");
`endif

endmodule
